[hw/rtl/lrupf_pkg.sv]
// ============================================================================
// lrupf_pkg: shared types and constants of the LRU page frame replacer
// Holds the controller state type, the controller-to-datapath command
// bundle and the fixed field widths of the ports.
// ============================================================================
package lrupf_pkg;

    // Fixed widths of the port fields.
    localparam int CAP_W      = 5;
    localparam int IN_PAGE_W  = 16;
    localparam int OUT_SLOT_W = 4;
    localparam int OUT_PAGE_W = 16;
    localparam int FAULT_W    = 32;

    // Capacity after reset.
    localparam int CAP_RESET  = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_UPDATE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the page number of the accepted beat
        logic lookup;   // compare all frames and register the decision
        logic commit;   // update frames, ranks, fault count and result
    } t_dp_cmd;

endpackage

[hw/rtl/lrupf_ctrl.sv]
// ============================================================================
// lrupf_ctrl: sequencing controller of the LRU page frame replacer
// Steps each accepted beat through the lookup and commit phases and
// drives the busy flag of the command interface.
// ============================================================================
module lrupf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output lrupf_pkg::t_dp_cmd o_cmd
);

    lrupf_pkg::t_state r_state;
    lrupf_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrupf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        busy          = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.lookup  = 1'b0;
        o_cmd.commit  = 1'b0;
        case (r_state)
            lrupf_pkg::ST_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lrupf_pkg::ST_MATCH;
                end
            end
            lrupf_pkg::ST_MATCH: begin
                busy         = 1'b1;
                o_cmd.lookup = 1'b1;
                n_state      = lrupf_pkg::ST_UPDATE;
            end
            lrupf_pkg::ST_UPDATE: begin
                // The next beat may be taken while this one commits.
                o_cmd.commit = 1'b1;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = lrupf_pkg::ST_MATCH;
                end else begin
                    n_state = lrupf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lrupf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/lrupf_datapath.sv]
// ============================================================================
// lrupf_datapath: frame store, recency ranks and fault counter
// Compares the referenced page against every active frame, picks the hit,
// empty or least recently used frame, and commits the update and result.
// ============================================================================
module lrupf_datapath #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lrupf_pkg::t_dp_cmd                  i_cmd,
    input  logic                                i_cfg_we,
    input  logic [lrupf_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic [lrupf_pkg::IN_PAGE_W-1:0]     i_page_number,
    output logic                                o_result_valid,
    output logic                                o_is_hit,
    output logic [lrupf_pkg::OUT_SLOT_W-1:0]    o_frame_slot,
    output logic                                o_evicted_valid,
    output logic [lrupf_pkg::OUT_PAGE_W-1:0]    o_evicted_page,
    output logic [lrupf_pkg::FAULT_W-1:0]       o_fault_total
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int ACT_W  = $clog2(FRAMES + 1);
    localparam int OSW    = lrupf_pkg::OUT_SLOT_W;
    localparam int OPW    = lrupf_pkg::OUT_PAGE_W;
    localparam int FW     = lrupf_pkg::FAULT_W;
    localparam int ACT_RESET = (lrupf_pkg::CAP_RESET > FRAMES) ? FRAMES
                                                               : lrupf_pkg::CAP_RESET;

    // Frame state.
    logic [PAGE_BITS-1:0] r_tag  [FRAMES];
    logic [RANK_W-1:0]    r_rank [FRAMES];
    logic [FRAMES-1:0]    r_vld;
    logic [FW-1:0]        r_faults;
    logic [ACT_W-1:0]     r_active;

    // Request and lookup decision.
    logic [PAGE_BITS-1:0] r_req_page;
    logic                 r_hit;
    logic                 r_empty;
    logic [IDX_W-1:0]     r_slot;
    logic [RANK_W-1:0]    r_limit;
    logic [PAGE_BITS-1:0] r_old_page;

    // Result registers.
    logic                 r_res_valid;
    logic                 r_res_hit;
    logic [IDX_W-1:0]     r_res_slot;
    logic                 r_res_evict;
    logic [PAGE_BITS-1:0] r_res_old;
    logic [FW-1:0]        r_res_faults;

    logic [FRAMES-1:0]    act_mask;
    logic [FRAMES-1:0]    match_vec;
    logic [FRAMES-1:0]    empty_vec;
    logic [FRAMES-1:0]    lru_vec;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     lru_idx;
    logic [RANK_W-1:0]    lru_rank;
    logic                 hit;
    logic                 empty;
    logic [IDX_W-1:0]     slot_sel;
    logic [ACT_W-1:0]     n_active;
    logic [FW-1:0]        n_faults;
    logic                 miss;

    // With every active frame full, the ranks are exactly 0 .. active-1, so
    // the least recently used frame is the one that holds the top rank.
    assign lru_rank = RANK_W'(r_active - ACT_W'(1));

    always_comb begin
        for (int j = 0; j < FRAMES; j++) begin
            act_mask[j]  = (ACT_W'(j) < r_active);
            match_vec[j] = r_vld[j] && act_mask[j] && (r_tag[j] == r_req_page);
            empty_vec[j] = !r_vld[j] && act_mask[j];
            lru_vec[j]   = r_vld[j] && act_mask[j] && (r_rank[j] == lru_rank);
        end
    end

    // Lowest-numbered frame wins in each search.
    always_comb begin
        hit_idx   = '0;
        empty_idx = '0;
        lru_idx   = '0;
        for (int j = FRAMES - 1; j >= 0; j--) begin
            if (match_vec[j]) begin
                hit_idx = IDX_W'(j);
            end
            if (empty_vec[j]) begin
                empty_idx = IDX_W'(j);
            end
            if (lru_vec[j]) begin
                lru_idx = IDX_W'(j);
            end
        end
    end

    assign hit      = |match_vec;
    assign empty    = |empty_vec;
    assign slot_sel = hit ? hit_idx : (empty ? empty_idx : lru_idx);
    assign miss     = !r_hit;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_active = ACT_W'(1);
        end else if (int'(i_cfg_wdata) > FRAMES) begin
            n_active = ACT_W'(FRAMES);
        end else begin
            n_active = ACT_W'(i_cfg_wdata);
        end
    end

    assign n_faults = (miss && (r_faults != '1)) ? r_faults + FW'(1) : r_faults;

    // Request capture and lookup decision.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_page <= PAGE_BITS'(i_page_number);
        end
        if (i_cmd.lookup) begin
            r_hit      <= hit;
            r_empty    <= empty;
            r_slot     <= slot_sel;
            r_limit    <= r_rank[hit_idx];
            r_old_page <= (!hit && !empty) ? r_tag[lru_idx] : '0;
        end
    end

    // Page tags are only read while valid, so they need no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && miss && !i_cfg_we) begin
            r_tag[r_slot] <= r_req_page;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_faults <= '0;
            r_active <= ACT_W'(ACT_RESET);
            for (int j = 0; j < FRAMES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cfg_we) begin
            r_vld    <= '0;
            r_faults <= '0;
            r_active <= n_active;
            for (int j = 0; j < FRAMES; j++) begin
                r_rank[j] <= '0;
            end
        end else if (i_cmd.commit) begin
            r_faults <= n_faults;
            if (miss) begin
                r_vld[r_slot] <= 1'b1;
            end
            for (int j = 0; j < FRAMES; j++) begin
                if (IDX_W'(j) == r_slot) begin
                    r_rank[j] <= '0;
                end else if (r_vld[j] && act_mask[j] && (miss || (r_rank[j] < r_limit))) begin
                    r_rank[j] <= r_rank[j] + RANK_W'(1);
                end
            end
        end
    end

    // Result strobe and payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.commit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res_hit    <= r_hit;
            r_res_slot   <= r_slot;
            r_res_evict  <= miss && !r_empty;
            r_res_old    <= r_old_page;
            r_res_faults <= n_faults;
        end
    end

    assign o_result_valid  = r_res_valid;
    assign o_is_hit        = r_res_hit;
    assign o_frame_slot    = OSW'(r_res_slot);
    assign o_evicted_valid = r_res_evict;
    assign o_evicted_page  = OPW'(r_res_old);
    assign o_fault_total   = r_res_faults;

    // A hit never replaces a page.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_is_hit) |-> (!o_evicted_valid && (o_evicted_page == '0)))
        else $error("hit result reports an eviction");

    // A fault result always carries a nonzero fault count.
    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_is_hit) |-> (o_fault_total != '0))
        else $error("fault result with zero fault count");

    // The fault count only moves up, except on a capacity write.
    a_faults_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(i_cfg_we)) |-> (r_faults >= $past(r_faults)))
        else $error("fault count decreased without a capacity write");

    // Results are single-cycle strobes, and a lookup phase always lies between two of them.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

endmodule

[hw/rtl/lru_page_frame_replacer_unit.sv]
// ============================================================================
// lru_page_frame_replacer_unit: LRU page frame replacer
// Fully associative page frame set with least recently used replacement,
// per-frame recency ranks and a saturating fault counter.
// ============================================================================
// Usage. A page reference is accepted on a rising edge where start is high
// and busy is low; i_page_number is sampled at that edge. The beat passes
// through the lookup phase, where every active frame is compared with
// the page in parallel and the hit, empty or least recently used frame is
// chosen, and then the commit phase, where frames, ranks and the
// fault count are updated. The result beat appears on the o_ ports for
// exactly one cycle, marked by o_result_valid, on the cycle after commit.
// busy is high only in the lookup phase, and a new reference may be
// accepted during commit, so the lookup-then-commit sequence of the frame
// store sets the sustained rate. The receiver cannot stall:
// each result must be taken in its single strobe cycle.
// The capacity register is written through i_cfg_we and i_cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write of 0 acts as 1, a value above FRAMES acts as
// FRAMES, and every write empties all frames and clears the fault count.
// Reset empties all frames, clears the fault count and sets capacity to 16, or to FRAMES if smaller.
// ============================================================================
module lru_page_frame_replacer_unit #(
    parameter int FRAMES    = 16,
    parameter int PAGE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [lrupf_pkg::IN_PAGE_W-1:0]     i_page_number,
    input  logic                                i_cfg_we,
    input  logic [lrupf_pkg::CAP_W-1:0]         i_cfg_wdata,
    output logic                                o_result_valid,
    output logic                                o_is_hit,
    output logic [lrupf_pkg::OUT_SLOT_W-1:0]    o_frame_slot,
    output logic                                o_evicted_valid,
    output logic [lrupf_pkg::OUT_PAGE_W-1:0]    o_evicted_page,
    output logic [lrupf_pkg::FAULT_W-1:0]       o_fault_total
);

    lrupf_pkg::t_dp_cmd cmd;

    // The controller sequences each beat through lookup and commit.
    lrupf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the frames, ranks, fault count and result registers.
    lrupf_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_page_number   (i_page_number),
        .o_result_valid  (o_result_valid),
        .o_is_hit        (o_is_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

endmodule

[verif/lrupf_tb_pkg.sv]
// ============================================================================
// lrupf_tb_pkg: scoreboard for the LRU page frame replacer testbench
// Keeps a private copy of the frame set, recency ranks and fault count. It
// works out the outcome of every accepted page reference and compares each
// result beat with the oldest outcome still outstanding.
// ============================================================================
package lrupf_tb_pkg;

    import lrupf_pkg::*;

    localparam int NUM_FRAMES   = 16;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic                  is_hit;
        logic [OUT_SLOT_W-1:0] frame_slot;
        logic                  evicted_valid;
        logic [OUT_PAGE_W-1:0] evicted_page;
        logic [FAULT_W-1:0]    fault_total;
    } t_outcome;

    class lrupf_scoreboard;

        logic [IN_PAGE_W-1:0] frame_page  [NUM_FRAMES];
        bit                   frame_valid [NUM_FRAMES];
        int unsigned          frame_rank  [NUM_FRAMES];
        logic [FAULT_W-1:0]   fault_count;
        int                   active_frames;
        t_outcome             pending_outcomes [$];

        int mismatches;
        int refs_seen;
        int hits_seen;
        int faults_seen;
        int evictions_seen;

        function new();
            mismatches     = 0;
            refs_seen      = 0;
            hits_seen      = 0;
            faults_seen    = 0;
            evictions_seen = 0;
            set_capacity(CAP_W'(CAP_RESET));
        endfunction

        // A capacity write empties every frame and clears the fault count.
        function void set_capacity(logic [CAP_W-1:0] value);
            if (value == 0) begin
                active_frames = 1;
            end else if (value > NUM_FRAMES) begin
                active_frames = NUM_FRAMES;
            end else begin
                active_frames = int'(value);
            end
            for (int j = 0; j < NUM_FRAMES; j++) begin
                frame_page[j]  = '0;
                frame_valid[j] = 1'b0;
                frame_rank[j]  = 0;
            end
            fault_count = '0;
        endfunction

        function void age_frames(int unsigned limit);
            for (int j = 0; j < active_frames; j++) begin
                if (frame_valid[j] && frame_rank[j] < limit) begin
                    frame_rank[j]++;
                end
            end
        endfunction

        // Works out the outcome of one accepted reference and queues it.
        function void note_page(logic [IN_PAGE_W-1:0] page);
            t_outcome    outc;
            int          slot;
            int unsigned oldest;
            outc.is_hit        = 1'b0;
            outc.evicted_valid = 1'b0;
            outc.evicted_page  = '0;
            slot = -1;
            for (int j = 0; j < active_frames; j++) begin
                if (slot < 0 && frame_valid[j] && frame_page[j] == page) begin
                    slot = j;
                end
            end
            if (slot >= 0) begin
                outc.is_hit = 1'b1;
                age_frames(frame_rank[slot]);
                frame_rank[slot] = 0;
            end else begin
                if (fault_count != '1) begin
                    fault_count++;
                end
                for (int j = 0; j < active_frames; j++) begin
                    if (slot < 0 && !frame_valid[j]) begin
                        slot = j;
                    end
                end
                if (slot >= 0) begin
                    age_frames(32'hFFFF_FFFF);
                    frame_valid[slot] = 1'b1;
                end else begin
                    // All active frames are full: the highest rank is the LRU frame.
                    slot   = 0;
                    oldest = 0;
                    for (int j = 0; j < active_frames; j++) begin
                        if (frame_rank[j] > oldest) begin
                            oldest = frame_rank[j];
                            slot   = j;
                        end
                    end
                    outc.evicted_valid = 1'b1;
                    outc.evicted_page  = frame_page[slot];
                    age_frames(32'hFFFF_FFFF);
                end
                frame_page[slot] = page;
                frame_rank[slot] = 0;
            end
            outc.frame_slot  = OUT_SLOT_W'(slot);
            outc.fault_total = fault_count;
            pending_outcomes.push_back(outc);
            refs_seen++;
            if (outc.is_hit) begin
                hits_seen++;
            end else begin
                faults_seen++;
            end
            if (outc.evicted_valid) begin
                evictions_seen++;
            end
        endfunction

        function void check_result(logic                  is_hit,
                                   logic [OUT_SLOT_W-1:0] frame_slot,
                                   logic                  evicted_valid,
                                   logic [OUT_PAGE_W-1:0] evicted_page,
                                   logic [FAULT_W-1:0]    fault_total);
            t_outcome want;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: result beat with no reference outstanding");
                end
                return;
            end
            want = pending_outcomes.pop_front();
            if (want.is_hit !== is_hit || want.frame_slot !== frame_slot ||
                want.evicted_valid !== evicted_valid ||
                want.evicted_page !== evicted_page ||
                want.fault_total !== fault_total) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("ERROR: hit %0b/%0b slot %0d/%0d evict %0b/%0b page %h/%h faults %0d/%0d (expected/actual)",
                             want.is_hit, is_hit, want.frame_slot, frame_slot,
                             want.evicted_valid, evicted_valid,
                             want.evicted_page, evicted_page,
                             want.fault_total, fault_total);
                end
            end
        endfunction

    endclass

endpackage

[verif/lru_page_frame_replacer_unit_tb.sv]
// ============================================================================
// lru_page_frame_replacer_unit_tb: testbench of the LRU page frame replacer
// Drives page references through the start/busy handshake, predicts every
// result beat with a scoreboard model of the frame set and checks each beat
// field by field. A directed part hits the capacity extremes, hits, fills and
// evictions; random phases follow with varied capacity and sender gaps.
// ============================================================================
module lru_page_frame_replacer_unit_tb;

    import lrupf_pkg::*;
    import lrupf_tb_pkg::*;

    localparam int PHASES      = 12;
    localparam int PHASE_BEATS = 50;
    localparam int POOL_MAX    = 24;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  start           = 1'b0;
    logic                  busy;
    logic [IN_PAGE_W-1:0]  i_page_number   = '0;
    logic                  i_cfg_we        = 1'b0;
    logic [CAP_W-1:0]      i_cfg_wdata     = '0;
    logic                  o_result_valid;
    logic                  o_is_hit;
    logic [OUT_SLOT_W-1:0] o_frame_slot;
    logic                  o_evicted_valid;
    logic [OUT_PAGE_W-1:0] o_evicted_page;
    logic [FAULT_W-1:0]    o_fault_total;

    lrupf_scoreboard sb = new();
    int              settings_applied = 0;

    lru_page_frame_replacer_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_page_number   (i_page_number),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_result_valid  (o_result_valid),
        .o_is_hit        (o_is_hit),
        .o_frame_slot    (o_frame_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_total   (o_fault_total)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The monitor runs in the active region of each rising edge, so it sees
    // the values that the block itself samples at that edge. A reference is
    // taken when start is high and busy is low; a result beat is taken in
    // the single cycle its strobe is high, since the receiver cannot stall.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_result_valid) begin
                sb.check_result(o_is_hit, o_frame_slot, o_evicted_valid,
                                o_evicted_page, o_fault_total);
            end
            if (start && !busy) begin
                sb.note_page(i_page_number);
            end
        end
    end

    // Presents one reference and returns at the edge that accepts it. Start
    // is left high so that a following reference keeps it asserted without
    // a second assignment in the same time step.
    task automatic send_page(input logic [IN_PAGE_W-1:0] page);
        start         <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    // Sender gap: start low for the given number of cycles, with junk on the
    // page bus that the block must ignore.
    task automatic hold_off(input int cycles);
        for (int k = 0; k < cycles; k++) begin
            start         <= 1'b0;
            i_page_number <= IN_PAGE_W'($urandom);
            @(posedge i_clk);
        end
    endtask

    // The capacity register is only written once the block has drained:
    // every outstanding result beat must have arrived first.
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        sb.set_capacity(value);
        settings_applied++;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One random phase. Pages come mostly from a working set of the capacity plus
    // up to four pages, so that hits, fills and LRU evictions all occur; the
    // rest are arbitrary 16-bit pages. Each cycle in which the sender could
    // offer a reference is left idle with the given percentage.
    task automatic run_phase(input logic [CAP_W-1:0] capacity, input int idle_pct);
        logic [IN_PAGE_W-1:0] pool [POOL_MAX];
        int                   pool_n;
        int                   active;
        logic [IN_PAGE_W-1:0] page;
        write_capacity(capacity);
        active = (capacity == 0) ? 1 : (capacity > NUM_FRAMES) ? NUM_FRAMES : int'(capacity);
        pool_n = active + $urandom_range(0, 4);
        for (int k = 0; k < POOL_MAX; k++) begin
            pool[k] = IN_PAGE_W'($urandom);
        end
        for (int n = 0; n < PHASE_BEATS; n++) begin
            while ($urandom_range(99) < idle_pct) begin
                hold_off(1);
            end
            if ($urandom_range(99) < 85) begin
                page = pool[$urandom_range(pool_n - 1)];
            end else begin
                page = IN_PAGE_W'($urandom);
            end
            send_page(page);
        end
    endtask

    initial begin
        int idle_modes [3];
        logic [CAP_W-1:0] cap_plan [PHASES];
        idle_modes = '{0, 62, 24};
        cap_plan   = '{5'd1, 5'd16, 5'd31, 5'd0, 5'd2, 5'd5, 5'd8, 5'd12,
                       5'd15, 5'd17, CAP_W'($urandom), CAP_W'($urandom)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, back to back. Reset capacity of 16: page extremes,
        // a hit on page zero and the pages on either side of the top-bit boundary.
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h8000);
        send_page(16'h7FFF);
        // A single frame: after the first fill, every new page evicts the previous one.
        write_capacity(5'd1);
        send_page(16'h0005);
        send_page(16'h0005);
        send_page(16'h0006);
        send_page(16'h0005);
        // A written zero behaves as one frame.
        write_capacity(5'd0);
        send_page(16'h0001);
        send_page(16'h0002);
        // Three frames: the hit on 10 makes 11 the LRU victim, then 12.
        write_capacity(5'd3);
        send_page(16'h000A);
        send_page(16'h000B);
        send_page(16'h000C);
        send_page(16'h000A);
        send_page(16'h000D);
        send_page(16'h000B);
        // A capacity above the frame count is clipped to all frames.
        write_capacity(5'd31);
        send_page(16'h1234);
        send_page(16'h1234);

        for (int p = 0; p < PHASES; p++) begin
            run_phase(cap_plan[p], idle_modes[p % 3]);
        end

        // Drain: wait for every outstanding beat, then wait on to catch any
        // stray strobe.
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending_outcomes.size() != 0) begin
            sb.mismatches++;
        end

        $display("Checked %0d references over %0d capacity writes:",
                 sb.refs_seen, settings_applied);
        $display("%0d hits, %0d faults, %0d evictions.",
                 sb.hits_seen, sb.faults_seen, sb.evictions_seen);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

endmodule
